[sv/lavm_pkg.sv]
// shared constants, types and index tables for the look-at view matrix pipeline
package lavm_pkg;

    localparam int IN_W       = 32;
    localparam int BW         = 16;
    localparam int QSHIFT     = 14;
    localparam int ONE_Q      = 16384;
    localparam int HALF_Q     = 8192;

    localparam int VEC_W      = 34;
    localparam int MAG_W      = 34;
    localparam int POS_W      = 6;
    localparam int NRM_W      = 30;
    localparam int NRM_TOP    = 29;
    localparam int SQ_W       = 60;
    localparam int SUM_W      = 62;
    localparam int SQ_STEPS   = 31;
    localparam int SQ_REM_W   = 33;
    localparam int SQ_ROOT_W  = 31;
    localparam int NUM_W      = 45;
    localparam int DIV_STEPS  = 15;
    localparam int DIV_REM_W  = 31;
    localparam int NORM_LAT   = 5 + SQ_STEPS + 1 + DIV_STEPS + 1;

    localparam int PP_W       = 2 * BW;
    localparam int PROD_W     = BW + IN_W;
    localparam int TR_W       = 50;

    localparam int S_DATA_W   = 9 * IN_W;
    localparam int M_DATA_W   = 9 * BW + 3 * IN_W;
    localparam int OUT_DEPTH  = 2;

    localparam int NXT [3] = '{1, 2, 0};
    localparam int PRV [3] = '{2, 0, 1};

    typedef logic signed [BW-1:0]    comp_t;
    typedef logic signed [VEC_W-1:0] vin_t;
    typedef logic signed [IN_W-1:0]  coord_t;

endpackage

[sv/lavm_dly.sv]
// fixed-depth delay line with shared advance enable
module lavm_dly #(
    parameter int W = lavm_pkg::IN_W,
    parameter int D = lavm_pkg::NORM_LAT
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);
    import lavm_pkg::*;

    logic [W-1:0] sr_reg [D];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sr_reg[0] <= din;
            for (int k = 1; k < D; k++)
            begin
                sr_reg[k] <= sr_reg[k-1];
            end
        end
    end

    assign dout = sr_reg[D-1];

endmodule

[sv/lavm_norm.sv]
// pipelined 3-vector normalizer to q1.14: scale, sum of squares, root, divide
module lavm_norm (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  lavm_pkg::vin_t  vin [3],
    output logic            out_valid,
    output lavm_pkg::comp_t vout [3]
);
    import lavm_pkg::*;

    logic [NORM_LAT-1:0] v_reg;

    logic [MAG_W-1:0] a_m_next [3];
    logic [MAG_W-1:0] a_mx_next;
    logic [MAG_W-1:0] a_m_reg [3];
    logic             a_s_reg [3];
    logic [MAG_W-1:0] a_mx_reg;

    logic [POS_W-1:0] b_p_next;
    logic [MAG_W-1:0] b_m_reg [3];
    logic             b_s_reg [3];
    logic [POS_W-1:0] b_p_reg;
    logic             b_z_reg;

    logic [NRM_W-1:0] c_m_next [3];
    logic [NRM_W-1:0] c_m_reg [3];
    logic             c_s_reg [3];
    logic             c_z_reg;

    logic [SQ_W-1:0]  d_sq_reg [3];
    logic [NRM_W-1:0] d_m_reg [3];
    logic             d_s_reg [3];
    logic             d_z_reg;

    logic [SUM_W-1:0] e_sum_reg;
    logic [NRM_W-1:0] e_m_reg [3];
    logic             e_s_reg [3];
    logic             e_z_reg;

    logic [SQ_REM_W-1:0]  sq_rem_reg  [SQ_STEPS];
    logic [SQ_ROOT_W-1:0] sq_root_reg [SQ_STEPS];
    logic [SUM_W-1:0]     sq_x_reg    [SQ_STEPS];
    logic [NRM_W-1:0]     sq_m_reg    [SQ_STEPS][3];
    logic                 sq_s_reg    [SQ_STEPS][3];
    logic                 sq_z_reg    [SQ_STEPS];

    logic [NUM_W-1:0]     n_num_reg [3];
    logic [SQ_ROOT_W-1:0] n_len_reg;
    logic                 n_s_reg [3];
    logic                 n_z_reg;

    logic [DIV_REM_W-1:0] dv_rem_reg [DIV_STEPS][3];
    logic [DIV_STEPS-1:0] dv_lo_reg  [DIV_STEPS][3];
    logic [DIV_STEPS-1:0] dv_q_reg   [DIV_STEPS][3];
    logic [SQ_ROOT_W-1:0] dv_len_reg [DIV_STEPS];
    logic                 dv_s_reg   [DIV_STEPS][3];
    logic                 dv_z_reg   [DIV_STEPS];

    comp_t o_next [3];
    comp_t o_reg  [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[NORM_LAT-2:0], in_valid};
        end
    end

    // magnitudes and largest magnitude
    always_comb
    begin
        a_mx_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            a_m_next[i] = vin[i][VEC_W-1] ? MAG_W'(-vin[i]) : MAG_W'(vin[i]);
            if (a_m_next[i] > a_mx_next)
            begin
                a_mx_next = a_m_next[i];
            end
        end
    end

    // leading one position
    always_comb
    begin
        b_p_next = '0;
        for (int j = 0; j < MAG_W; j++)
        begin
            if (a_mx_reg[j])
            begin
                b_p_next = POS_W'(j);
            end
        end
    end

    // common scale so the largest lands in [2^29, 2^30)
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (b_p_reg > POS_W'(NRM_TOP))
            begin
                c_m_next[i] = NRM_W'(b_m_reg[i] >> (b_p_reg - POS_W'(NRM_TOP)));
            end
            else
            begin
                c_m_next[i] = NRM_W'(b_m_reg[i] << (POS_W'(NRM_TOP) - b_p_reg));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                a_m_reg[i]  <= a_m_next[i];
                a_s_reg[i]  <= vin[i][VEC_W-1];
                b_m_reg[i]  <= a_m_reg[i];
                b_s_reg[i]  <= a_s_reg[i];
                c_m_reg[i]  <= c_m_next[i];
                c_s_reg[i]  <= b_s_reg[i];
                d_sq_reg[i] <= SQ_W'(c_m_reg[i]) * SQ_W'(c_m_reg[i]);
                d_m_reg[i]  <= c_m_reg[i];
                d_s_reg[i]  <= c_s_reg[i];
                e_m_reg[i]  <= d_m_reg[i];
                e_s_reg[i]  <= d_s_reg[i];
            end
            a_mx_reg  <= a_mx_next;
            b_p_reg   <= b_p_next;
            b_z_reg   <= (a_mx_reg == '0);
            c_z_reg   <= b_z_reg;
            d_z_reg   <= c_z_reg;
            e_sum_reg <= SUM_W'(d_sq_reg[0]) + SUM_W'(d_sq_reg[1]) + SUM_W'(d_sq_reg[2]);
            e_z_reg   <= d_z_reg;
        end
    end

    // integer square root, one result bit per stage
    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_sq
        logic [SQ_REM_W-1:0]  rem_in;
        logic [SQ_ROOT_W-1:0] root_in;
        logic [SUM_W-1:0]     x_in;
        logic [NRM_W-1:0]     m_in [3];
        logic                 s_in [3];
        logic                 z_in;
        logic [SQ_REM_W+1:0]  r;
        logic [SQ_REM_W+1:0]  t;

        if (k == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign x_in    = e_sum_reg;
            assign z_in    = e_z_reg;
            for (genvar i = 0; i < 3; i++)
            begin : g_c
                assign m_in[i] = e_m_reg[i];
                assign s_in[i] = e_s_reg[i];
            end
        end
        else
        begin : g_rest
            assign rem_in  = sq_rem_reg[k-1];
            assign root_in = sq_root_reg[k-1];
            assign x_in    = sq_x_reg[k-1];
            assign z_in    = sq_z_reg[k-1];
            for (genvar i = 0; i < 3; i++)
            begin : g_c
                assign m_in[i] = sq_m_reg[k-1][i];
                assign s_in[i] = sq_s_reg[k-1][i];
            end
        end

        assign r = {rem_in, x_in[SUM_W-1 -: 2]};
        assign t = {2'b00, root_in, 2'b01};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (r >= t)
                begin
                    sq_rem_reg[k]  <= SQ_REM_W'(r - t);
                    sq_root_reg[k] <= {root_in[SQ_ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    sq_rem_reg[k]  <= r[SQ_REM_W-1:0];
                    sq_root_reg[k] <= {root_in[SQ_ROOT_W-2:0], 1'b0};
                end
                sq_x_reg[k] <= {x_in[SUM_W-3:0], 2'b00};
                sq_z_reg[k] <= z_in;
                for (int i = 0; i < 3; i++)
                begin
                    sq_m_reg[k][i] <= m_in[i];
                    sq_s_reg[k][i] <= s_in[i];
                end
            end
        end
    end

    // numerator with half-length rounding term
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                n_num_reg[i] <= {1'b0, sq_m_reg[SQ_STEPS-1][i], {QSHIFT{1'b0}}}
                              + NUM_W'(sq_root_reg[SQ_STEPS-1] >> 1);
                n_s_reg[i]   <= sq_s_reg[SQ_STEPS-1][i];
            end
            n_len_reg <= sq_root_reg[SQ_STEPS-1];
            n_z_reg   <= sq_z_reg[SQ_STEPS-1];
        end
    end

    // restoring division, one quotient bit per stage
    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_dv
        logic [DIV_REM_W-1:0] rem_in [3];
        logic [DIV_STEPS-1:0] lo_in  [3];
        logic [DIV_STEPS-1:0] q_in   [3];
        logic                 s_in   [3];
        logic [SQ_ROOT_W-1:0] len_in;
        logic                 z_in;
        logic [DIV_REM_W:0]   r  [3];
        logic                 ge [3];

        if (k == 0)
        begin : g_first
            assign len_in = n_len_reg;
            assign z_in   = n_z_reg;
            for (genvar i = 0; i < 3; i++)
            begin : g_c
                assign rem_in[i] = {1'b0, n_num_reg[i][NUM_W-1:DIV_STEPS]};
                assign lo_in[i]  = n_num_reg[i][DIV_STEPS-1:0];
                assign q_in[i]   = '0;
                assign s_in[i]   = n_s_reg[i];
            end
        end
        else
        begin : g_rest
            assign len_in = dv_len_reg[k-1];
            assign z_in   = dv_z_reg[k-1];
            for (genvar i = 0; i < 3; i++)
            begin : g_c
                assign rem_in[i] = dv_rem_reg[k-1][i];
                assign lo_in[i]  = dv_lo_reg[k-1][i];
                assign q_in[i]   = dv_q_reg[k-1][i];
                assign s_in[i]   = dv_s_reg[k-1][i];
            end
        end

        for (genvar i = 0; i < 3; i++)
        begin : g_cmp
            assign r[i]  = {rem_in[i], lo_in[i][DIV_STEPS-1]};
            assign ge[i] = (r[i] >= {1'b0, len_in});
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (ge[i])
                    begin
                        dv_rem_reg[k][i] <= DIV_REM_W'(r[i] - {1'b0, len_in});
                    end
                    else
                    begin
                        dv_rem_reg[k][i] <= r[i][DIV_REM_W-1:0];
                    end
                    dv_q_reg[k][i]  <= {q_in[i][DIV_STEPS-2:0], ge[i]};
                    dv_lo_reg[k][i] <= {lo_in[i][DIV_STEPS-2:0], 1'b0};
                    dv_s_reg[k][i]  <= s_in[i];
                end
                dv_len_reg[k] <= len_in;
                dv_z_reg[k]   <= z_in;
            end
        end
    end

    // clamp, sign and zero vector
    always_comb
    begin
        logic [DIV_STEPS-1:0] qc;
        for (int i = 0; i < 3; i++)
        begin
            qc = dv_q_reg[DIV_STEPS-1][i];
            if (qc > DIV_STEPS'(ONE_Q))
            begin
                qc = DIV_STEPS'(ONE_Q);
            end
            if (dv_z_reg[DIV_STEPS-1])
            begin
                o_next[i] = '0;
            end
            else if (dv_s_reg[DIV_STEPS-1][i])
            begin
                o_next[i] = -comp_t'({1'b0, qc});
            end
            else
            begin
                o_next[i] = comp_t'({1'b0, qc});
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                o_reg[i] <= o_next[i];
            end
        end
    end

    assign out_valid = v_reg[NORM_LAT-1];
    assign vout      = o_reg;

endmodule

[sv/look_at_view_matrix.sv]
// look-at camera view basis and translation, fully pipelined
//
// usage
//   s_axis carries one camera setup per beat: eye, target and approximate up,
//   each three signed q16.16 words. m_axis returns one beat per setup: the
//   right, up and backward axes in q1.14 and the three saturated q16.16
//   translations (negated dot products of each axis with the eye).
// pipeline and throughput
//   a new beat is taken every cycle while s_axis_tready is high. each beat
//   goes through one input stage, three normalizer passes of 53 stages each
//   (the 31-stage square root and 15-stage divider set that depth), two
//   2-stage cross products, a 3-stage translation and the output buffer.
//   forward and up-in normalize side by side in the first pass.
// reset
//   rst_n clears all valid bits and the output buffer; no setup is needed.
// stalls
//   a 2-beat output buffer absorbs the pipeline; when it is full the whole
//   pipeline holds and s_axis_tready drops until m_axis_tready takes a beat.
module look_at_view_matrix (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // eye_x, eye_y, eye_z, target_x, target_y, target_z, upin_x, upin_y, upin_z
    input  logic [lavm_pkg::S_DATA_W-1:0] s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // right_x..z, upout_x..z, fwd_x..z, trans_x, trans_y, trans_z
    output logic [lavm_pkg::M_DATA_W-1:0] m_axis_tdata
);
    import lavm_pkg::*;

    localparam int FWD_DLY = NORM_LAT + 2;
    localparam int EYE_DLY = 3 * NORM_LAT + 4;

    logic en;

    coord_t i_eye_reg [3];
    vin_t   i_dif_reg [3];
    vin_t   i_up_reg  [3];
    logic   i_v_reg;

    comp_t f_vec [3];
    comp_t u_vec [3];
    comp_t r_vec [3];
    comp_t y_vec [3];
    logic  f_v, u_v, r_v, y_v;

    logic signed [PP_W-1:0] x1_p_reg [6];
    vin_t                   x2_c_reg [3];
    logic                   x1_v_reg, x2_v_reg;

    logic signed [PP_W-1:0] y1_p_reg [6];
    vin_t                   y2_c_reg [3];
    logic                   y1_v_reg, y2_v_reg;

    logic [3*BW-1:0]   fx_d1, fx_d2, rx_d;
    logic [3*IN_W-1:0] eye_d;

    comp_t  fx1 [3];
    comp_t  t_b [3][3];
    coord_t t_eye [3];

    logic signed [PROD_W-1:0] t1_p_reg [3][3];
    comp_t                    t1_b_reg [3][3];
    logic signed [TR_W-1:0]   t2_reg   [3];
    comp_t                    t2_b_reg [3][3];
    coord_t                   t3_tr_reg [3];
    comp_t                    t3_b_reg [3][3];
    logic                     t1_v_reg, t2_v_reg, t3_v_reg;

    logic [M_DATA_W-1:0] t3_word;
    logic [M_DATA_W-1:0] fq_reg [OUT_DEPTH];
    logic                wp_reg, rp_reg;
    logic [1:0]          cnt_reg;
    logic                push, pop;

    assign en            = (cnt_reg != 2'(OUT_DEPTH));
    assign s_axis_tready = en;

    // input stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                i_eye_reg[i] <= s_axis_tdata[IN_W*i +: IN_W];
                i_dif_reg[i] <= VEC_W'(coord_t'(s_axis_tdata[IN_W*i +: IN_W]))
                              - VEC_W'(coord_t'(s_axis_tdata[IN_W*(3+i) +: IN_W]));
                i_up_reg[i]  <= VEC_W'(coord_t'(s_axis_tdata[IN_W*(6+i) +: IN_W]));
            end
        end
    end

    lavm_norm u_norm_f (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (i_v_reg),
        .vin       (i_dif_reg),
        .out_valid (f_v),
        .vout      (f_vec)
    );

    lavm_norm u_norm_u (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (i_v_reg),
        .vin       (i_up_reg),
        .out_valid (u_v),
        .vout      (u_vec)
    );

    // right = up x fwd
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                x1_p_reg[2*i]   <= u_vec[NXT[i]] * f_vec[PRV[i]];
                x1_p_reg[2*i+1] <= u_vec[PRV[i]] * f_vec[NXT[i]];
                x2_c_reg[i]     <= VEC_W'(x1_p_reg[2*i]) - VEC_W'(x1_p_reg[2*i+1]);
            end
        end
    end

    lavm_norm u_norm_r (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (x2_v_reg),
        .vin       (x2_c_reg),
        .out_valid (r_v),
        .vout      (r_vec)
    );

    lavm_dly #(.W(3*BW), .D(FWD_DLY)) u_dly_f1 (
        .clk  (clk),
        .en   (en),
        .din  ({f_vec[2], f_vec[1], f_vec[0]}),
        .dout (fx_d1)
    );

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            fx1[i] = fx_d1[BW*i +: BW];
        end
    end

    // up = fwd x right
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                y1_p_reg[2*i]   <= fx1[NXT[i]] * r_vec[PRV[i]];
                y1_p_reg[2*i+1] <= fx1[PRV[i]] * r_vec[NXT[i]];
                y2_c_reg[i]     <= VEC_W'(y1_p_reg[2*i]) - VEC_W'(y1_p_reg[2*i+1]);
            end
        end
    end

    lavm_norm u_norm_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (y2_v_reg),
        .vin       (y2_c_reg),
        .out_valid (y_v),
        .vout      (y_vec)
    );

    lavm_dly #(.W(3*BW), .D(FWD_DLY)) u_dly_f2 (
        .clk  (clk),
        .en   (en),
        .din  (fx_d1),
        .dout (fx_d2)
    );

    lavm_dly #(.W(3*BW), .D(FWD_DLY)) u_dly_r (
        .clk  (clk),
        .en   (en),
        .din  ({r_vec[2], r_vec[1], r_vec[0]}),
        .dout (rx_d)
    );

    lavm_dly #(.W(3*IN_W), .D(EYE_DLY)) u_dly_eye (
        .clk  (clk),
        .en   (en),
        .din  ({i_eye_reg[2], i_eye_reg[1], i_eye_reg[0]}),
        .dout (eye_d)
    );

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            t_b[0][i] = rx_d[BW*i +: BW];
            t_b[1][i] = y_vec[i];
            t_b[2][i] = fx_d2[BW*i +: BW];
            t_eye[i]  = eye_d[IN_W*i +: IN_W];
        end
    end

    // translation: products, negated rounded sum, shift and saturate
    always_ff @(posedge clk)
    begin
        logic signed [TR_W-1:0] sh;
        if (en)
        begin
            for (int b = 0; b < 3; b++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    t1_p_reg[b][i] <= t_b[b][i] * t_eye[i];
                    t1_b_reg[b][i] <= t_b[b][i];
                    t2_b_reg[b][i] <= t1_b_reg[b][i];
                    t3_b_reg[b][i] <= t2_b_reg[b][i];
                end
                t2_reg[b] <= TR_W'(HALF_Q) - (TR_W'(t1_p_reg[b][0]) + TR_W'(t1_p_reg[b][1])
                                             + TR_W'(t1_p_reg[b][2]));
                sh = t2_reg[b] >>> QSHIFT;
                if (sh[TR_W-1:IN_W-1] == '0 || sh[TR_W-1:IN_W-1] == '1)
                begin
                    t3_tr_reg[b] <= sh[IN_W-1:0];
                end
                else if (sh[TR_W-1])
                begin
                    t3_tr_reg[b] <= {1'b1, {(IN_W-1){1'b0}}};
                end
                else
                begin
                    t3_tr_reg[b] <= {1'b0, {(IN_W-1){1'b1}}};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_v_reg  <= 1'b0;
            x1_v_reg <= 1'b0;
            x2_v_reg <= 1'b0;
            y1_v_reg <= 1'b0;
            y2_v_reg <= 1'b0;
            t1_v_reg <= 1'b0;
            t2_v_reg <= 1'b0;
            t3_v_reg <= 1'b0;
        end
        else if (en)
        begin
            i_v_reg  <= s_axis_tvalid;
            x1_v_reg <= f_v & u_v;
            x2_v_reg <= x1_v_reg;
            y1_v_reg <= r_v;
            y2_v_reg <= y1_v_reg;
            t1_v_reg <= y_v;
            t2_v_reg <= t1_v_reg;
            t3_v_reg <= t2_v_reg;
        end
    end

    assign t3_word = {t3_tr_reg[2], t3_tr_reg[1], t3_tr_reg[0],
                      t3_b_reg[2][2], t3_b_reg[2][1], t3_b_reg[2][0],
                      t3_b_reg[1][2], t3_b_reg[1][1], t3_b_reg[1][0],
                      t3_b_reg[0][2], t3_b_reg[0][1], t3_b_reg[0][0]};

    // output buffer
    assign push = en & t3_v_reg;
    assign pop  = m_axis_tvalid & m_axis_tready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fq_reg[wp_reg] <= t3_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    assign m_axis_tvalid = (cnt_reg != '0);
    assign m_axis_tdata  = fq_reg[rp_reg];

endmodule

[sv/lavm_chk.sv]
// port-level checks for the look-at view matrix block
module lavm_chk (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [lavm_pkg::M_DATA_W-1:0] m_axis_tdata
);
    import lavm_pkg::*;

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output beat dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output beat changed while stalled");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[BW-1:0]) <= 16'sd16384
                           && $signed(m_axis_tdata[BW-1:0]) >= -16'sd16384))
        else $error("right_x out of unit range");

    a_zero_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[9*BW-1:6*BW] == '0) |-> (m_axis_tdata == '0))
        else $error("zero forward axis gave nonzero basis or translation");

    a_idle_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

bind look_at_view_matrix lavm_chk u_lavm_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
